FILE: design/aotd_pkg.sv
package aotd_pkg;

  // sample width of the adc code
  localparam int SAMPLE_BITS = 12;
  localparam int THR_BITS    = 12;
  localparam int TIME_BITS   = 32;
  localparam int MS_BITS     = 16;
  localparam int CFG_BITS    = 16;
  localparam int CFG_IDX_BITS = 2;

  // compare width: wide enough for sample plus hysteresis without overflow
  localparam int CMP_BITS = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  // register reset values
  localparam logic [THR_BITS-1:0] THRESHOLD_RST  = THR_BITS'(2730);
  localparam logic [THR_BITS-1:0] HYSTERESIS_RST = THR_BITS'(137);
  localparam logic [MS_BITS-1:0]  ARM_TIME_RST   = MS_BITS'(50);
  localparam logic [MS_BITS-1:0]  TRIG_TIME_RST  = MS_BITS'(80);

  typedef enum logic [1:0] {
    PH_WAIT_LOW  = 2'd0,
    PH_ARMED     = 2'd1,
    PH_TRIGGERED = 2'd2
  } phase_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_HYSTERESIS = 2'd1,
    REG_ARM_TIME   = 2'd2,
    REG_TRIG_TIME  = 2'd3
  } reg_idx_t;

endpackage

FILE: design/armed_overvoltage_trip_detector_unit.sv
// channel | direction | handshake           | payload
// in      | input     | in_valid / in_stall | in_sample, in_time_ms
// out     | output    | out_valid/out_stall | out_mode, out_trip, out_hold_on
// cfg     | input     | cfg_we              | cfg_idx, cfg_wdata
//
// one beat per cycle sustained while out_stall is low; a beat goes from input to output through
// (input register, then compare/subtract logic into the output register)
// the phase latch and the two timers update when a beat moves into the output register
// out_stall holds the output register and, once the input register is full, raises in_stall
// rst_n (synchronous) clears the phase to wait-low and both timers, and loads the config registers' reset values
module armed_overvoltage_trip_detector_unit
  import aotd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SAMPLE_BITS-1:0]   in_sample,
  input  logic [TIME_BITS-1:0]     in_time_ms,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_mode,
  output logic                     out_trip,
  output logic                     out_hold_on,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_BITS-1:0]      cfg_wdata
);

  logic [THR_BITS-1:0]    threshold_r;
  logic [THR_BITS-1:0]    hysteresis_r;
  logic [MS_BITS-1:0]     arm_time_r;
  logic [MS_BITS-1:0]     trig_time_r;

  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [TIME_BITS-1:0]   s1_time_r;

  phase_t                 phase_r, phase_nxt;
  logic [TIME_BITS-1:0]   low_start_r, low_start_nxt;
  logic                   low_started_r, low_started_nxt;
  logic [TIME_BITS-1:0]   high_start_r, high_start_nxt;
  logic                   high_started_r, high_started_nxt;
  logic                   trip_nxt;

  logic                   out_valid_r;
  logic [1:0]             out_mode_r;
  logic                   out_trip_r;
  logic                   out_hold_r;

  logic                   s1_adv;
  logic                   in_acc;
  logic                   below_arm;
  logic                   above_thr;
  logic [TIME_BITS-1:0]   low_elapsed;
  logic [TIME_BITS-1:0]   high_elapsed;

  // handshake
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r  <= THRESHOLD_RST;
      hysteresis_r <= HYSTERESIS_RST;
      arm_time_r   <= ARM_TIME_RST;
      trig_time_r  <= TRIG_TIME_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_THRESHOLD:  threshold_r  <= cfg_wdata[THR_BITS-1:0];
        REG_HYSTERESIS: hysteresis_r <= cfg_wdata[THR_BITS-1:0];
        REG_ARM_TIME:   arm_time_r   <= cfg_wdata[MS_BITS-1:0];
        REG_TRIG_TIME:  trig_time_r  <= cfg_wdata[MS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample;
      s1_time_r   <= in_time_ms;
    end
  end

  // level compares; sample + hysteresis < threshold covers a negative arm level
  assign below_arm = (CMP_BITS'(s1_sample_r) + CMP_BITS'(hysteresis_r)) < CMP_BITS'(threshold_r);
  assign above_thr = CMP_BITS'(s1_sample_r) > CMP_BITS'(threshold_r);

  // elapsed time, wraps modulo 2^32
  assign low_elapsed  = s1_time_r - low_start_r;
  assign high_elapsed = s1_time_r - high_start_r;

  // next phase and timers
  always_comb begin
    phase_nxt        = phase_r;
    low_start_nxt    = low_start_r;
    low_started_nxt  = low_started_r;
    high_start_nxt   = high_start_r;
    high_started_nxt = high_started_r;
    trip_nxt         = 1'b0;
    unique case (phase_r)
      PH_WAIT_LOW: begin
        if (below_arm) begin
          if (!low_started_r) begin
            low_start_nxt   = s1_time_r;
            low_started_nxt = 1'b1;
          end else if (low_elapsed >= TIME_BITS'(arm_time_r)) begin
            phase_nxt = PH_ARMED;
          end
        end else begin
          low_started_nxt = 1'b0;
        end
      end
      PH_ARMED: begin
        if (above_thr) begin
          if (!high_started_r) begin
            high_start_nxt   = s1_time_r;
            high_started_nxt = 1'b1;
          end else if (high_elapsed >= TIME_BITS'(trig_time_r)) begin
            phase_nxt = PH_TRIGGERED;
            trip_nxt  = 1'b1;
          end
        end else begin
          high_started_nxt = 1'b0;
        end
      end
      PH_TRIGGERED: ;
      default: ;
    endcase
  end

  // state register, updated as each beat leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_WAIT_LOW;
      low_start_r    <= '0;
      low_started_r  <= 1'b0;
      high_start_r   <= '0;
      high_started_r <= 1'b0;
    end else if (s1_adv) begin
      phase_r        <= phase_nxt;
      low_start_r    <= low_start_nxt;
      low_started_r  <= low_started_nxt;
      high_start_r   <= high_start_nxt;
      high_started_r <= high_started_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_mode_r <= phase_nxt;
      out_trip_r <= trip_nxt;
      out_hold_r <= (phase_nxt != PH_TRIGGERED);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_mode    = out_mode_r;
  assign out_trip    = out_trip_r;
  assign out_hold_on = out_hold_r;

endmodule

FILE: design/aotd_checker.sv
module aotd_checker
  import aotd_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic [SAMPLE_BITS-1:0]  in_sample,
  input logic [TIME_BITS-1:0]    in_time_ms,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [1:0]              out_mode,
  input logic                    out_trip,
  input logic                    out_hold_on
);

  logic seen_trig_r;

  // remembers that a triggered beat has gone out since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_trig_r <= 1'b0;
    end else if (out_valid && !out_stall && (out_mode == PH_TRIGGERED)) begin
      seen_trig_r <= 1'b1;
    end
  end

  // trip only on a beat that reports triggered
  a_trip_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trip |-> (out_mode == PH_TRIGGERED))
    else $error("trip without triggered mode");

  // hold output is the inverse of triggered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hold_on == (out_mode != PH_TRIGGERED)))
    else $error("hold_on disagrees with mode");

  // triggered latches until reset, and trips only once
  a_latch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_trig_r |-> (out_mode == PH_TRIGGERED) && !out_trip)
    else $error("left triggered or tripped twice");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_mode) && $stable(out_trip))
    else $error("stalled result beat changed");

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_sample) && $stable(in_time_ms))
    else $error("stalled input beat changed");

endmodule

bind armed_overvoltage_trip_detector_unit aotd_checker u_aotd_checker (.*);
